/* rtl/lhcb_pkg.sv */
// Shared types, codes and constants of the link health circuit breaker.
package lhcb_pkg;

    localparam int CNT_W  = 24;
    localparam int TIME_W = 32;
    localparam int CFG_W  = 16;
    localparam int PCT_W  = 7;
    localparam int IDX_W  = 3;

    localparam logic [CNT_W-1:0] CNT_MAX      = {CNT_W{1'b1}};
    localparam logic [7:0]       PERCENT_BASE = 8'd100;

    typedef enum logic [1:0] {
        OP_RESULT  = 2'd0,
        OP_AVAIL   = 2'd1,
        OP_EXCEPT  = 2'd2,
        OP_TIMEOUT = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        CAUSE_NONE    = 3'd0,
        CAUSE_CONSEC  = 3'd1,
        CAUSE_RATIO   = 3'd2,
        CAUSE_TIMEOUT = 3'd3,
        CAUSE_EXCEPT  = 3'd4
    } t_cause;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_STAB_INTERVAL = 3'd0;
    localparam logic [IDX_W-1:0] REG_CONSEC_WINDOW = 3'd1;
    localparam logic [IDX_W-1:0] REG_CONSEC_LIMIT  = 3'd2;
    localparam logic [IDX_W-1:0] REG_MIN_FAIL      = 3'd3;
    localparam logic [IDX_W-1:0] REG_FAIL_PERCENT  = 3'd4;
    localparam logic [IDX_W-1:0] REG_RETRY_INTERVAL = 3'd5;

    typedef struct packed {
        logic [CFG_W-1:0] stability_interval;
        logic [CFG_W-1:0] consecutive_window;
        logic [CFG_W-1:0] consecutive_limit;
        logic [CFG_W-1:0] min_fail_count;
        logic [PCT_W-1:0] fail_percent;
        logic [CFG_W-1:0] retry_interval;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        stability_interval: 16'd60,
        consecutive_window: 16'd5,
        consecutive_limit:  16'd5,
        min_fail_count:     16'd2,
        fail_percent:       7'd50,
        retry_interval:     16'd30
    };

    typedef struct packed {
        logic   active;
        logic   may_try;
        logic   close_link;
        t_cause cause;
    } t_res;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? CNT_MAX : v + 1'b1;
    endfunction

endpackage

/* rtl/lhcb_core.sv */
// Breaker state registers and the combinational event update.
module lhcb_core
    import lhcb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  t_op               i_op,
    input  logic [TIME_W-1:0] i_now,
    input  logic              i_flag,
    input  t_cfg              i_cfg,
    output t_res              o_res
);

    logic              r_active, n_active;
    logic              r_tmo_flag, n_tmo_flag;
    logic              r_exc_flag, n_exc_flag;
    logic [TIME_W-1:0] r_next_ratio, n_next_ratio;
    logic [CNT_W-1:0]  r_total, n_total;
    logic [CNT_W-1:0]  r_fail, n_fail;
    logic [TIME_W-1:0] r_consec_dl, n_consec_dl;
    logic [CNT_W-1:0]  r_consec, n_consec;
    logic [TIME_W-1:0] r_next_retry, n_next_retry;

    logic [TIME_W-1:0] retry_at;
    logic [TIME_W-1:0] ratio_at;
    logic [TIME_W-1:0] window_at;
    logic [CNT_W-1:0]  total_inc;
    logic [CNT_W-1:0]  fail_inc;
    logic [CNT_W-1:0]  fail_new;
    logic [CNT_W-1:0]  consec_inc;
    logic [TIME_W-1:0] dl_new;
    logic [31:0]       fail_scaled;
    logic [31:0]       pct_scaled;
    logic              ratio_hit;
    logic              consec_hit;

    assign retry_at   = i_now + {{(TIME_W-CFG_W){1'b0}}, i_cfg.retry_interval};
    assign ratio_at   = i_now + {{(TIME_W-CFG_W){1'b0}}, i_cfg.stability_interval};
    assign window_at  = i_now + {{(TIME_W-CFG_W){1'b0}}, i_cfg.consecutive_window};
    assign total_inc  = sat_inc(r_total);
    assign fail_inc   = sat_inc(r_fail);
    assign consec_inc = sat_inc(r_consec);
    assign fail_new   = i_flag ? fail_inc : r_fail;
    assign dl_new     = (r_consec == '0) ? window_at : r_consec_dl;
    assign consec_hit = (consec_inc >= {{(CNT_W-CFG_W){1'b0}}, i_cfg.consecutive_limit}) &&
                        (i_now >= dl_new);

    // fail >= floor(pct*total/100)  <=>  (fail+1)*100 > pct*total
    assign fail_scaled = ({{(32-CNT_W){1'b0}}, fail_new} + 32'd1) *
                         {24'd0, PERCENT_BASE};
    assign pct_scaled  = {{(32-PCT_W){1'b0}}, i_cfg.fail_percent} *
                         {{(32-CNT_W){1'b0}}, total_inc};
    assign ratio_hit   = fail_scaled > pct_scaled;

    always_comb begin
        n_active     = r_active;
        n_tmo_flag   = r_tmo_flag;
        n_exc_flag   = r_exc_flag;
        n_next_ratio = r_next_ratio;
        n_total      = r_total;
        n_fail       = r_fail;
        n_consec_dl  = r_consec_dl;
        n_consec     = r_consec;
        n_next_retry = r_next_retry;
        o_res.may_try = 1'b0;
        o_res.cause   = CAUSE_NONE;

        if (i_fire) begin
            case (i_op)
                OP_RESULT: begin
                    if (!r_active) begin
                        if (!i_flag) begin
                            n_next_ratio = ratio_at;
                            n_total      = {{(CNT_W-1){1'b0}}, 1'b1};
                            n_fail       = '0;
                            n_consec_dl  = '0;
                            n_consec     = '0;
                            n_active     = 1'b1;
                            n_tmo_flag   = 1'b0;
                            n_exc_flag   = 1'b0;
                        end
                    end else begin
                        n_total = total_inc;
                        if (i_flag) begin
                            n_fail      = fail_inc;
                            n_consec_dl = dl_new;
                            n_consec    = consec_inc;
                        end else begin
                            n_consec = '0;
                        end
                        if (i_flag && consec_hit) begin
                            n_active     = 1'b0;
                            n_next_retry = retry_at;
                            o_res.cause  = CAUSE_CONSEC;
                        end else if (i_now >= r_next_ratio) begin
                            n_next_ratio = ratio_at;
                            if (i_flag && (fail_new >= {{(CNT_W-CFG_W){1'b0}},
                                                        i_cfg.min_fail_count}) && ratio_hit) begin
                                n_active     = 1'b0;
                                n_next_retry = retry_at;
                                o_res.cause  = CAUSE_RATIO;
                            end else begin
                                // open a fresh interval
                                n_total = '0;
                                n_fail  = '0;
                            end
                        end
                    end
                end
                OP_AVAIL: begin
                    if (r_active) begin
                        o_res.may_try = 1'b1;
                    end else if (i_now >= r_next_retry) begin
                        n_next_retry  = retry_at;
                        o_res.may_try = 1'b1;
                    end
                end
                OP_EXCEPT: begin
                    n_exc_flag = i_flag;
                    if (i_flag) begin
                        n_active     = 1'b0;
                        n_next_retry = retry_at;
                        o_res.cause  = CAUSE_EXCEPT;
                    end else begin
                        n_active = 1'b1;
                    end
                end
                OP_TIMEOUT: begin
                    if (i_flag != r_tmo_flag) begin
                        n_tmo_flag = i_flag;
                        if (i_flag) begin
                            n_active     = 1'b0;
                            n_next_retry = retry_at;
                            o_res.cause  = CAUSE_TIMEOUT;
                        end
                    end
                end
                default: begin
                    n_active = r_active;
                end
            endcase
        end

        o_res.active     = n_active;
        o_res.close_link = (o_res.cause != CAUSE_NONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active     <= 1'b1;
            r_tmo_flag   <= 1'b0;
            r_exc_flag   <= 1'b0;
            r_next_ratio <= '0;
            r_total      <= '0;
            r_fail       <= '0;
            r_consec_dl  <= '0;
            r_consec     <= '0;
            r_next_retry <= '0;
        end else begin
            r_active     <= n_active;
            r_tmo_flag   <= n_tmo_flag;
            r_exc_flag   <= n_exc_flag;
            r_next_ratio <= n_next_ratio;
            r_total      <= n_total;
            r_fail       <= n_fail;
            r_consec_dl  <= n_consec_dl;
            r_consec     <= n_consec;
            r_next_retry <= n_next_retry;
        end
    end

endmodule

/* rtl/link_health_circuit_breaker.sv */
// Link health circuit breaker: event input register, breaker core, result register.
//
// One event in, one result out. An event (op, now, flag) transfers on the input
// channel when i_in_valid is high and o_in_stall is low; the result (active,
// may_try, close_link, cause) transfers when o_out_valid is high and
// i_out_stall is low. The configuration port writes one register per cycle
// while i_cfg_wr_en is high; write it only while no event is in flight.
// From input transfer to o_out_valid the event lands in the input register,
// and the breaker update then loads the result register together with the
// new breaker state. Throughput is one event per cycle while the receiver
// does not stall. When the receiver stalls, the result register holds and
// the input register holds one more event; o_in_stall rises only when both
// are full. Reset (synchronous, active low) enables the link, clears all
// counters and times, empties both registers and loads the default
// configuration.
module link_health_circuit_breaker
    import lhcb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [1:0]        i_op,
    input  logic [TIME_W-1:0] i_now,
    input  logic              i_flag,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_active,
    output logic              o_may_try,
    output logic              o_close_link,
    output logic [2:0]        o_cause,
    input  logic              i_cfg_wr_en,
    input  logic [IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_wdata
);

    t_cfg              r_cfg;
    logic              r_in_valid;
    t_op               r_op;
    logic [TIME_W-1:0] r_now;
    logic              r_flag;
    logic              r_out_valid;
    t_res              r_res;
    t_res              core_res;
    logic              advance;
    logic              fire;
    logic              in_take;

    assign advance    = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_STAB_INTERVAL:  r_cfg.stability_interval <= i_cfg_wdata;
                REG_CONSEC_WINDOW:  r_cfg.consecutive_window <= i_cfg_wdata;
                REG_CONSEC_LIMIT:   r_cfg.consecutive_limit  <= i_cfg_wdata;
                REG_MIN_FAIL:       r_cfg.min_fail_count     <= i_cfg_wdata;
                REG_FAIL_PERCENT:   r_cfg.fail_percent       <= i_cfg_wdata[PCT_W-1:0];
                REG_RETRY_INTERVAL: r_cfg.retry_interval     <= i_cfg_wdata;
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_op   <= t_op'(i_op);
            r_now  <= i_now;
            r_flag <= i_flag;
        end
    end

    lhcb_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_op    (r_op),
        .i_now   (r_now),
        .i_flag  (r_flag),
        .i_cfg   (r_cfg),
        .o_res   (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_res <= core_res;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_active     = r_res.active;
    assign o_may_try    = r_res.may_try;
    assign o_close_link = r_res.close_link;
    assign o_cause      = r_res.cause;

endmodule

/* rtl/lhcb_chk.sv */
// Port-level checks for the link health circuit breaker, bound to the top level.
module lhcb_chk
    import lhcb_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic              o_active,
    input logic              o_may_try,
    input logic              o_close_link,
    input logic [2:0]        o_cause
);

    // a disabling event always leaves the link disabled
    a_close_inactive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_close_link |-> !o_active)
        else $error("close_link with link still active");

    a_cause_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_close_link == (o_cause != CAUSE_NONE)))
        else $error("cause and close_link disagree");

    // only availability checks grant a try, and they never disable
    a_try_no_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_may_try |-> !o_close_link)
        else $error("may_try together with close_link");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_active) &&
        $stable(o_may_try) && $stable(o_close_link) && $stable(o_cause))
        else $error("stalled result changed");

endmodule

bind link_health_circuit_breaker lhcb_chk u_chk (.*);

/* dv/tb.sv */
// Testbench for the link health circuit breaker: event stimulus, breaker prediction, result checks.
`timescale 1ns / 100ps

module tb;
    import lhcb_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;

    // Tracks breaker state and configuration, and queues the verdict each event should produce.
    class breaker_tracker;
        logic [CFG_W-1:0]  stab_ivl;
        logic [CFG_W-1:0]  win_len;
        logic [CFG_W-1:0]  run_limit;
        logic [CFG_W-1:0]  min_fails;
        logic [PCT_W-1:0]  fail_pct;
        logic [CFG_W-1:0]  retry_ivl;
        logic              enabled;
        logic              tmo_set;
        logic              exc_set;
        logic [TIME_W-1:0] ratio_due;
        logic [TIME_W-1:0] run_due;
        logic [TIME_W-1:0] retry_due;
        logic [CNT_W-1:0]  calls;
        logic [CNT_W-1:0]  fails;
        logic [CNT_W-1:0]  run_len;
        t_res              due_verdicts[$];
        int                errors;

        function new();
            stab_ivl  = CFG_RESET.stability_interval;
            win_len   = CFG_RESET.consecutive_window;
            run_limit = CFG_RESET.consecutive_limit;
            min_fails = CFG_RESET.min_fail_count;
            fail_pct  = CFG_RESET.fail_percent;
            retry_ivl = CFG_RESET.retry_interval;
            enabled   = 1'b1;
            tmo_set   = 1'b0;
            exc_set   = 1'b0;
            ratio_due = '0;
            run_due   = '0;
            retry_due = '0;
            calls     = '0;
            fails     = '0;
            run_len   = '0;
            errors    = 0;
        endfunction

        function void set_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                REG_STAB_INTERVAL:  stab_ivl  = val;
                REG_CONSEC_WINDOW:  win_len   = val;
                REG_CONSEC_LIMIT:   run_limit = val;
                REG_MIN_FAIL:       min_fails = val;
                REG_FAIL_PERCENT:   fail_pct  = val[PCT_W-1:0];
                REG_RETRY_INTERVAL: retry_ivl = val;
                default: ;
            endcase
        endfunction

        function logic [CNT_W-1:0] bump(logic [CNT_W-1:0] v);
            return (&v) ? v : v + 1'b1;
        endfunction

        function void trip(logic [TIME_W-1:0] now);
            enabled   = 1'b0;
            retry_due = now + retry_ivl;
        endfunction

        function void take_event(logic [1:0] op, logic [TIME_W-1:0] now, logic flag);
            t_res        want;
            t_cause      why;
            logic        tried;
            logic [63:0] bar;
            why   = CAUSE_NONE;
            tried = 1'b0;
            case (op)
                OP_RESULT: begin
                    if (!enabled) begin
                        // a success revives a disabled link with a fresh interval
                        if (!flag) begin
                            ratio_due = now + stab_ivl;
                            calls     = {{(CNT_W-1){1'b0}}, 1'b1};
                            fails     = '0;
                            run_due   = '0;
                            run_len   = '0;
                            enabled   = 1'b1;
                            tmo_set   = 1'b0;
                            exc_set   = 1'b0;
                        end
                    end else begin
                        calls = bump(calls);
                        if (flag) begin
                            fails = bump(fails);
                            if (run_len == 0)
                                run_due = now + win_len;
                            run_len = bump(run_len);
                            if (run_len >= run_limit && now >= run_due) begin
                                trip(now);
                                why = CAUSE_CONSEC;
                            end
                        end else begin
                            run_len = '0;
                        end
                        if (why == CAUSE_NONE && now >= ratio_due) begin
                            bar       = fail_pct;
                            bar       = bar * calls / PERCENT_BASE;
                            ratio_due = now + stab_ivl;
                            if (flag && fails >= min_fails && fails >= bar) begin
                                trip(now);
                                why = CAUSE_RATIO;
                            end else begin
                                calls = '0;
                                fails = '0;
                            end
                        end
                    end
                end
                OP_AVAIL: begin
                    if (enabled) begin
                        tried = 1'b1;
                    end else if (now >= retry_due) begin
                        retry_due = now + retry_ivl;
                        tried     = 1'b1;
                    end
                end
                OP_EXCEPT: begin
                    if (flag) begin
                        exc_set = 1'b1;
                        trip(now);
                        why = CAUSE_EXCEPT;
                    end else begin
                        exc_set = 1'b0;
                        enabled = 1'b1;
                    end
                end
                default: begin
                    if (flag != tmo_set) begin
                        tmo_set = flag;
                        if (flag) begin
                            trip(now);
                            why = CAUSE_TIMEOUT;
                        end
                    end
                end
            endcase
            want.active     = enabled;
            want.may_try    = tried;
            want.close_link = (why != CAUSE_NONE);
            want.cause      = why;
            due_verdicts.push_back(want);
        endfunction

        function void match_verdict(logic act, logic may, logic cls, logic [2:0] why);
            t_res want;
            if (due_verdicts.size() == 0) begin
                $error("result transfer with no event outstanding");
                errors++;
                return;
            end
            want = due_verdicts.pop_front();
            if (act !== want.active) begin
                $error("active: expected %0b, actual %0b", want.active, act);
                errors++;
            end
            if (may !== want.may_try) begin
                $error("may_try: expected %0b, actual %0b", want.may_try, may);
                errors++;
            end
            if (cls !== want.close_link) begin
                $error("close_link: expected %0b, actual %0b", want.close_link, cls);
                errors++;
            end
            if (why !== want.cause) begin
                $error("cause: expected %0d, actual %0d", want.cause, why);
                errors++;
            end
        endfunction

        function int outstanding();
            return due_verdicts.size();
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    logic [1:0]        i_op;
    logic [TIME_W-1:0] i_now;
    logic              i_flag;
    logic              o_out_valid;
    logic              i_out_stall;
    logic              o_active;
    logic              o_may_try;
    logic              o_close_link;
    logic [2:0]        o_cause;
    logic              i_cfg_wr_en;
    logic [IDX_W-1:0]  i_cfg_index;
    logic [CFG_W-1:0]  i_cfg_wdata;

    breaker_tracker    tracker;
    logic [TIME_W-1:0] link_time;
    bit                quiet;
    int                stall_left;
    int                cycles;
    int                phase;

    link_health_circuit_breaker dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_op         (i_op),
        .i_now        (i_now),
        .i_flag       (i_flag),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_active     (o_active),
        .o_may_try    (o_may_try),
        .o_close_link (o_close_link),
        .o_cause      (o_cause),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // mostly short gaps, now and then a long one; none in quiet stretches
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    always @(negedge i_clk) begin
        if (quiet) begin
            i_out_stall = 1'b0;
        end else if (stall_left > 0) begin
            i_out_stall = 1'b1;
            stall_left--;
        end else begin
            i_out_stall = 1'b0;
            if ($urandom_range(0, 3) == 0)
                stall_left = pick_gap();
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                tracker.take_event(i_op, i_now, i_flag);
            if (o_out_valid && !i_out_stall)
                tracker.match_verdict(o_active, o_may_try, o_close_link, o_cause);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Hold the payload until the transfer; leave valid high on return.
    task automatic send_event(t_op op, logic [TIME_W-1:0] now, logic flag);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_op       = op;
        i_now      = now;
        i_flag     = flag;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_wr_en = 1'b1;
        i_cfg_index = idx;
        i_cfg_wdata = val;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
        tracker.set_reg(idx, val);
    endtask

    task automatic program_regs(logic [CFG_W-1:0] stab, logic [CFG_W-1:0] win,
                                logic [CFG_W-1:0] lim, logic [CFG_W-1:0] minf,
                                logic [CFG_W-1:0] pct, logic [CFG_W-1:0] retry);
        write_reg(REG_STAB_INTERVAL, stab);
        write_reg(REG_CONSEC_WINDOW, win);
        write_reg(REG_CONSEC_LIMIT, lim);
        write_reg(REG_MIN_FAIL, minf);
        write_reg(REG_FAIL_PERCENT, pct);
        write_reg(REG_RETRY_INTERVAL, retry);
    endtask

    task automatic wait_drained();
        while (tracker.outstanding() != 0)
            @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Bursts of events on a mostly advancing clock; each burst has its own failure bias.
    task automatic run_traffic(int count);
        int     k;
        int     r;
        int     fail_bias;
        t_op    op;
        logic   flag;
        fail_bias = 50;
        for (k = 0; k < count; k++) begin
            if (k % 40 == 0) begin
                fail_bias = $urandom_range(0, 100);
                quiet     = ($urandom_range(0, 5) == 0);
            end
            r = $urandom_range(0, 99);
            if (r < 3)
                link_time = $urandom;
            else if (r < 10)
                link_time = link_time + $urandom_range(10, 400);
            else
                link_time = link_time + $urandom_range(0, 3);
            r = $urandom_range(0, 99);
            if (r < 60)
                op = OP_RESULT;
            else if (r < 80)
                op = OP_AVAIL;
            else if (r < 90)
                op = OP_EXCEPT;
            else
                op = OP_TIMEOUT;
            if (op == OP_RESULT)
                flag = ($urandom_range(0, 99) < fail_bias);
            else
                flag = 1'($urandom_range(0, 1));
            send_event(op, link_time, flag);
        end
        i_in_valid = 1'b0;
        quiet      = 1'b0;
    endtask

    initial begin
        tracker     = new();
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_op        = OP_RESULT;
        i_now       = '0;
        i_flag      = 1'b0;
        i_out_stall = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = '0;
        i_cfg_wdata = '0;
        quiet       = 1'b0;
        stall_left  = 0;
        cycles      = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // default settings: walk the breaker through each way in and out
        send_event(OP_AVAIL, 32'd0, 1'b0);
        send_event(OP_RESULT, 32'd0, 1'b0);
        send_event(OP_RESULT, 32'd1, 1'b1);
        send_event(OP_RESULT, 32'd2, 1'b1);
        send_event(OP_RESULT, 32'd3, 1'b1);
        send_event(OP_RESULT, 32'd4, 1'b1);
        send_event(OP_RESULT, 32'd6, 1'b1);
        send_event(OP_RESULT, 32'd7, 1'b1);
        send_event(OP_AVAIL, 32'd10, 1'b1);
        send_event(OP_AVAIL, 32'd36, 1'b0);
        send_event(OP_RESULT, 32'd37, 1'b0);
        send_event(OP_TIMEOUT, 32'd38, 1'b1);
        send_event(OP_TIMEOUT, 32'd39, 1'b1);
        send_event(OP_TIMEOUT, 32'd40, 1'b0);
        send_event(OP_EXCEPT, 32'd41, 1'b0);
        send_event(OP_EXCEPT, 32'd42, 1'b1);
        send_event(OP_EXCEPT, 32'd43, 1'b1);
        send_event(OP_EXCEPT, 32'd44, 1'b0);
        send_event(OP_RESULT, 32'd50, 1'b1);
        send_event(OP_RESULT, 32'd51, 1'b1);
        send_event(OP_RESULT, 32'd100, 1'b1);
        send_event(OP_AVAIL, 32'hFFFF_FFFF, 1'b0);
        send_event(OP_RESULT, 32'hFFFF_FFFF, 1'b0);
        send_event(OP_RESULT, 32'd0, 1'b1);
        send_event(OP_TIMEOUT, 32'hFFFF_FFFF, 1'b1);
        i_in_valid = 1'b0;
        link_time  = 32'd200;
        run_traffic(250);

        for (phase = 1; phase <= 6; phase++) begin
            wait_drained();
            case (phase)
                1: program_regs(16'd1, 16'd0, 16'd1, 16'd0, 16'd0, 16'd1);
                2: program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd100, 16'hFFFF);
                3: program_regs(16'd10, 16'd3, 16'd3, 16'd1, 16'd127, 16'd7);
                default: program_regs(16'($urandom_range(1, 120)),
                                      16'($urandom_range(0, 10)),
                                      16'($urandom_range(1, 8)),
                                      16'($urandom_range(0, 5)),
                                      16'($urandom_range(0, 100)),
                                      16'($urandom_range(1, 60)));
            endcase
            // start near the top of the time range so interval sums wrap
            if (phase == 2)
                link_time = 32'hFFFF_0000;
            else if (phase == 3)
                link_time = 32'hFFFF_FFC0;
            run_traffic((phase == 2) ? 200 : 230);
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.outstanding() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
